// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define CRSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define CRSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/crse_pkg.sv =====
// Package for the Catmull-Rom spline evaluator: constants, payload types
// and the fixed-point helper functions. No dependencies.
package crse_pkg;

    // Store and position format
    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int T_W        = 22;
    localparam int SEG_W      = T_W - FRAC_BITS;
    localparam int IDX_W      = 6;
    localparam int COORD_W    = 32;
    localparam int CNT_W      = 7;
    localparam int TAPS       = 4;
    localparam int AXES       = 3;

    // Four-bank point store: point n lives in bank n mod 4
    localparam int BANKS      = 4;
    localparam int BSEL_W     = $clog2(BANKS);
    localparam int BANK_DEPTH = (MAX_POINTS + BANKS - 1) / BANKS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Range check width: holds segment+3 and the point count
    localparam int SPAN_W     = SEG_W + 1;
    localparam int CMP_W      = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;

    // Datapath widths: Horner sums and products
    localparam int S_W        = 40;
    localparam int P_W        = S_W + FRAC_BITS + 1;

    // Queue between front and back, back pipeline depth
    localparam int FIFO_DEPTH  = 2;
    localparam int FQ_AW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int BACK_STAGES = 9;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // Rounding and saturation constants
    localparam logic signed [P_W-1:0] RND_HALF = P_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [S_W-1:0] SAT_HI   =
        {{(S_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [S_W-1:0] SAT_LO   = ~SAT_HI;

    typedef struct packed {
        logic                        kind;
        logic [IDX_W-1:0]            point_index;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_y;
        logic signed [COORD_W-1:0]   coord_z;
        logic [T_W-1:0]              t_position;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   out_x;
        logic signed [COORD_W-1:0]   out_y;
        logic signed [COORD_W-1:0]   out_z;
        logic                        out_of_range;
    } res_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [COORD_W-1:0]   z;
    } pt_t;

    typedef struct packed {
        logic                        oor;
        logic [FRAC_BITS-1:0]        frac;
    } side_t;

    // One queue entry: a classified write or evaluate
    typedef struct packed {
        logic                             kind;
        logic                             wr_ok;
        logic [IDX_W-1:0]                 wr_idx;
        pt_t                              wr_pt;
        logic [BANKS-1:0][BANK_AW-1:0]    rd_addr;
        logic [BSEL_W-1:0]                rot;
        side_t                            side;
    } q_t;

    typedef struct packed {
        logic signed [S_W-1:0] a;
        logic signed [S_W-1:0] b;
        logic signed [S_W-1:0] c;
        logic signed [S_W-1:0] d;
    } coef_t;

    // Cubic coefficients of one axis (all exact, scaled by two)
    function automatic coef_t crse_coef(input logic signed [COORD_W-1:0] p0,
                                        input logic signed [COORD_W-1:0] p1,
                                        input logic signed [COORD_W-1:0] p2,
                                        input logic signed [COORD_W-1:0] p3);
        logic signed [S_W-1:0] e0;
        logic signed [S_W-1:0] e1;
        logic signed [S_W-1:0] e2;
        logic signed [S_W-1:0] e3;
        coef_t                 r;
        e0  = S_W'(p0);
        e1  = S_W'(p1);
        e2  = S_W'(p2);
        e3  = S_W'(p3);
        r.a = e1 <<< 1;
        r.b = e2 - e0;
        r.c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        r.d = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
        return r;
    endfunction

    // Signed sum times unsigned fraction
    function automatic logic signed [P_W-1:0] crse_mul(input logic signed [S_W-1:0] s,
                                                       input logic [FRAC_BITS-1:0] f);
        logic signed [FRAC_BITS:0] fs;
        fs = {1'b0, f};
        return P_W'(s) * P_W'(fs);
    endfunction

    // Drop the fraction bits, rounding half toward plus infinity
    function automatic logic signed [S_W-1:0] crse_rnd(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] y;
        y = (v + RND_HALF) >>> FRAC_BITS;
        return y[S_W-1:0];
    endfunction

    // Halve with rounding, then clamp to the coordinate range
    function automatic logic signed [COORD_W-1:0] crse_sat(input logic signed [S_W-1:0] s);
        logic signed [S_W-1:0] h;
        h = (s + S_W'(1)) >>> 1;
        if (h > SAT_HI) begin
            h = SAT_HI;
        end
        else if (h < SAT_LO) begin
            h = SAT_LO;
        end
        return h[COORD_W-1:0];
    endfunction

endpackage

// ===== sv/crse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for each bank of the point store.
module crse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/crse_front.sv =====
// Front end: point-count register, item intake and classification.
// Depends on crse_pkg; feeds the entry queue.
module crse_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [crse_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  crse_pkg::item_t              item,
    input  logic                         q_full,
    output logic                         push,
    output crse_pkg::q_t                 entry
);
    import crse_pkg::*;

    logic [CNT_W-1:0]   point_count_reg;
    logic [CNT_W-1:0]   point_count_next;
    logic [SEG_W-1:0]   seg;
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   last_pt;
    logic [BSEL_W-1:0]  lane_ofs [BANKS];
    logic [SPAN_W-1:0]  lane_pt  [BANKS];

    // Config register, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        point_count_next = point_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            point_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else
        begin
            point_count_reg <= point_count_next;
        end
    end

    // Intake: stall only on a full queue
    assign item_stall = q_full;
    assign push       = item_valid && !item_stall;

    // Segment split and range check against min(point_count, MAX_POINTS)
    assign seg     = item.t_position[T_W-1:FRAC_BITS];
    assign limit   = (32'(point_count_reg) > MAX_POINTS) ? CMP_W'(MAX_POINTS)
                                                         : CMP_W'(point_count_reg);
    assign last_pt = CMP_W'(seg) + CMP_W'(TAPS - 1);

    // Per-bank read address: the one of segment..segment+3 held by each bank
    always_comb
    begin
        for (int k = 0; k < BANKS; k++)
        begin
            lane_ofs[k] = BSEL_W'(k) - seg[BSEL_W-1:0];
            lane_pt[k]  = SPAN_W'(seg) + SPAN_W'(lane_ofs[k]);
        end
    end

    // Queue entry
    always_comb
    begin
        entry.kind      = item.kind;
        entry.wr_ok     = 32'(item.point_index) < MAX_POINTS;
        entry.wr_idx    = item.point_index;
        entry.wr_pt.x   = item.coord_x;
        entry.wr_pt.y   = item.coord_y;
        entry.wr_pt.z   = item.coord_z;
        entry.rot       = seg[BSEL_W-1:0];
        entry.side.oor  = last_pt >= limit;
        entry.side.frac = item.t_position[FRAC_BITS-1:0];
        for (int k = 0; k < BANKS; k++)
        begin
            entry.rd_addr[k] = BANK_AW'(lane_pt[k] >> BSEL_W);
        end
    end

endmodule

// ===== sv/crse_fifo.sv =====
// Short entry queue between front and back end.
// Depends on crse_pkg for the entry type and depth.
module crse_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crse_pkg::q_t    wdata,
    output logic            full,
    input  logic            pop,
    output crse_pkg::q_t    head,
    output logic            head_valid
);
    import crse_pkg::*;

    q_t                 ent_reg [FIFO_DEPTH];
    logic [FQ_AW-1:0]   wr_ptr_reg;
    logic [FQ_AW-1:0]   wr_ptr_next;
    logic [FQ_AW-1:0]   rd_ptr_reg;
    logic [FQ_AW-1:0]   rd_ptr_next;
    logic [FQ_AW:0]     count_reg;
    logic [FQ_AW:0]     count_next;
    logic               do_pop;

    assign full       = count_reg == (FQ_AW + 1)'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = ent_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + FQ_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + FQ_AW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + (FQ_AW + 1)'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - (FQ_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/crse_back.sv =====
// Back end: four-bank point store and the Horner evaluation pipeline.
// Depends on crse_pkg and crse_ram; drains the entry queue.
module crse_back (
    input  logic            clk,
    input  logic            rst_n,
    input  crse_pkg::q_t    head,
    input  logic            head_valid,
    output logic            pop,
    output logic            result_valid,
    input  logic            result_stall,
    output crse_pkg::res_t  result
);
    import crse_pkg::*;

    logic                       advance;
    logic                       pop_eval;
    logic [BANKS-1:0]           bank_we;
    logic [BANK_AW-1:0]         wr_addr;
    pt_t                        bank_rd [BANKS];
    pt_t                        tap     [TAPS];

    logic [BACK_STAGES-1:0]     vld_reg;
    logic [BSEL_W-1:0]          rot0_reg;
    side_t                      side_reg [BACK_STAGES-1];

    coef_t                      coef1_reg [AXES];
    coef_t                      coef1_next [AXES];
    logic signed [P_W-1:0]      prod2_reg [AXES];
    logic signed [P_W-1:0]      prod2_next [AXES];
    coef_t                      cf2_reg [AXES];
    logic signed [S_W-1:0]      s3_reg [AXES];
    logic signed [S_W-1:0]      s3_next [AXES];
    coef_t                      cf3_reg [AXES];
    logic signed [P_W-1:0]      prod4_reg [AXES];
    logic signed [P_W-1:0]      prod4_next [AXES];
    coef_t                      cf4_reg [AXES];
    logic signed [S_W-1:0]      s5_reg [AXES];
    logic signed [S_W-1:0]      s5_next [AXES];
    coef_t                      cf5_reg [AXES];
    logic signed [P_W-1:0]      prod6_reg [AXES];
    logic signed [P_W-1:0]      prod6_next [AXES];
    coef_t                      cf6_reg [AXES];
    logic signed [S_W-1:0]      s7_reg [AXES];
    logic signed [S_W-1:0]      s7_next [AXES];
    res_t                       result_reg;
    res_t                       result_next;

    // Whole pipeline moves when the output slot is free or being taken
    assign advance  = !vld_reg[BACK_STAGES-1] || !result_stall;
    assign pop      = advance && head_valid;
    assign pop_eval = pop && (head.kind == KIND_EVAL);

    // Writes go to the store in queue order, so later reads see them
    assign wr_addr = BANK_AW'(head.wr_idx >> BSEL_W);

    always_comb
    begin
        for (int k = 0; k < BANKS; k++)
        begin
            bank_we[k] = pop && (head.kind == KIND_WRITE) && head.wr_ok &&
                         (head.wr_idx[BSEL_W-1:0] == BSEL_W'(k));
        end
    end

    for (genvar k = 0; k < BANKS; k++)
    begin : g_bank
        crse_ram #(
            .WIDTH ($bits(pt_t)),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[k]),
            .waddr (wr_addr),
            .wdata (head.wr_pt),
            .re    (advance),
            .raddr (head.rd_addr[k]),
            .rdata (bank_rd[k])
        );
    end

    // Put the four bank outputs back in point order
    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            tap[j] = bank_rd[BSEL_W'(rot0_reg + BSEL_W'(j))];
        end
    end

    // Stage logic: coefficients, then three Horner multiply/round-add pairs
    always_comb
    begin
        coef1_next[0] = crse_coef(tap[0].x, tap[1].x, tap[2].x, tap[3].x);
        coef1_next[1] = crse_coef(tap[0].y, tap[1].y, tap[2].y, tap[3].y);
        coef1_next[2] = crse_coef(tap[0].z, tap[1].z, tap[2].z, tap[3].z);
        for (int ax = 0; ax < AXES; ax++)
        begin
            prod2_next[ax] = crse_mul(coef1_reg[ax].d, side_reg[1].frac);
            s3_next[ax]    = cf2_reg[ax].c + crse_rnd(prod2_reg[ax]);
            prod4_next[ax] = crse_mul(s3_reg[ax], side_reg[3].frac);
            s5_next[ax]    = cf4_reg[ax].b + crse_rnd(prod4_reg[ax]);
            prod6_next[ax] = crse_mul(s5_reg[ax], side_reg[5].frac);
            s7_next[ax]    = cf6_reg[ax].a + crse_rnd(prod6_reg[ax]);
        end
    end

    // Final halving and clamp, or zeros when out of range
    always_comb
    begin
        result_next.out_x        = crse_sat(s7_reg[0]);
        result_next.out_y        = crse_sat(s7_reg[1]);
        result_next.out_z        = crse_sat(s7_reg[2]);
        result_next.out_of_range = side_reg[BACK_STAGES-2].oor;
        if (side_reg[BACK_STAGES-2].oor)
        begin
            result_next.out_x = '0;
            result_next.out_y = '0;
            result_next.out_z = '0;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[BACK_STAGES-2:0], pop_eval};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rot0_reg    <= head.rot;
            side_reg[0] <= head.side;
            for (int i = 1; i < BACK_STAGES - 1; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int ax = 0; ax < AXES; ax++)
            begin
                coef1_reg[ax] <= coef1_next[ax];
                prod2_reg[ax] <= prod2_next[ax];
                cf2_reg[ax]   <= coef1_reg[ax];
                s3_reg[ax]    <= s3_next[ax];
                cf3_reg[ax]   <= cf2_reg[ax];
                prod4_reg[ax] <= prod4_next[ax];
                cf4_reg[ax]   <= cf3_reg[ax];
                s5_reg[ax]    <= s5_next[ax];
                cf5_reg[ax]   <= cf4_reg[ax];
                prod6_reg[ax] <= prod6_next[ax];
                cf6_reg[ax]   <= cf5_reg[ax];
                s7_reg[ax]    <= s7_next[ax];
            end
            result_reg <= result_next;
        end
    end

    assign result_valid = vld_reg[BACK_STAGES-1];
    assign result       = result_reg;

endmodule

// ===== sv/catmull_rom_spline_eval_core.sv =====
// Top level of the uniform Catmull-Rom spline evaluator.
// Depends on crse_pkg, crse_front, crse_fifo, crse_back and assert_macros.svh.
//
//  Channel   Direction  Handshake     Payload
//  item      in         valid/stall   crse_pkg::item_t (point write or evaluate)
//  result    out        valid/stall   crse_pkg::res_t (one per evaluate)
//  cfg       in         valid/ready   point_count, 7 bits
//
// One item per cycle sustained while the output is not stalled; the four-bank
// store delivers all four points of a segment in one read, and the back end is
// a 9-stage pipeline. A result becomes valid once its item has passed the queue
// and the back-end stages, and it transfers at an edge with result_stall low.
// Reset clears point_count, the queue and the pipeline; the store is undefined.
// result_stall freezes the back end while a result waits; the 2-entry queue keeps
// taking items until it fills, then item_stall rises.
`include "assert_macros.svh"

module catmull_rom_spline_eval_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [crse_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  crse_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output crse_pkg::res_t               result
);
    import crse_pkg::*;

    logic   q_full;
    logic   q_push;
    q_t     q_in;
    q_t     q_head;
    logic   q_head_valid;
    logic   q_pop;

    // Intake and classification
    crse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (q_push),
        .entry      (q_in)
    );

    // Decoupling queue
    crse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wdata      (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    // Store and evaluation pipeline
    crse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_head_valid),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Out-of-range results carry zero coordinates
    `CRSE_ASSERT_IMP(a_oor_zero, result_valid && result.out_of_range,
        result.out_x == '0 && result.out_y == '0 && result.out_z == '0,
        "out-of-range result with nonzero coordinates")

    // A free output drains the queue, so intake cannot be stalled next cycle
    `CRSE_ASSERT_NXT(a_drain, !result_stall, !item_stall,
        "intake stalled after a cycle with the output free")

    // A full queue that is not draining means a result is waiting at the output
    `CRSE_ASSERT_IMP(a_stall_cause, item_stall && !q_pop, result_valid && result_stall,
        "full queue frozen without a stalled result")

endmodule

// ===== tb/catmull_rom_spline_eval_core_test.sv =====
// Self-checking testbench for catmull_rom_spline_eval_core: a directed table, then random
// point writes and spline evaluations under several idling mixes, checked by a local predictor.
// Depends on crse_pkg and the RTL of the evaluator only.
module catmull_rom_spline_eval_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import crse_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESULT_LATENCY = 10;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;

    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        item_t              it;
        bit                 typed;
        res_t               res;
        logic [CNT_W-1:0]   cfg;
    } plan_row_t;

    // Block ports
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data     = '0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    item_t              item_word    = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    res_t               result_word;

    // Predictor state: point store and the point count register
    pt_t                point_store [MAX_POINTS];
    logic [CNT_W-1:0]   active_count = '0;
    res_t               expected_results [$];
    plan_row_t          plan [$];

    // Idling control and bookkeeping
    int                 snd_idle_pct  = 0;
    int                 rcv_idle_pct  = 0;
    int                 hold_requests = 0;
    int                 hold_served   = 0;
    int                 hold_left     = 0;
    int                 failures      = 0;
    int                 checked       = 0;
    int                 n_writes      = 0;
    int                 n_evals       = 0;
    int                 n_misses      = 0;
    int                 n_settings    = 0;
    int                 cycle_count   = 0;

    catmull_rom_spline_eval_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: long holds on request, otherwise random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("Unexpected result: x %h y %h z %h oor %b",
                             result_word.out_x, result_word.out_y, result_word.out_z,
                             result_word.out_of_range);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                checked++;
                if (result_word.out_x !== want.out_x || result_word.out_y !== want.out_y ||
                    result_word.out_z !== want.out_z ||
                    result_word.out_of_range !== want.out_of_range)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                    begin
                        $display("Result %0d mismatch: exp x %h y %h z %h oor %b",
                                 checked, want.out_x, want.out_y, want.out_z,
                                 want.out_of_range);
                        $display("                     got x %h y %h z %h oor %b",
                                 result_word.out_x, result_word.out_y, result_word.out_z,
                                 result_word.out_of_range);
                    end
                end
            end
        end
    end

    // Drop the fraction bits, rounding half toward plus infinity
    function automatic longint drop_frac(input longint v);
        return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // One axis of the uniform cubic, Horner form, halved and clamped
    function automatic logic signed [COORD_W-1:0] spline_axis(
        input logic signed [COORD_W-1:0] p0, input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2, input logic signed [COORD_W-1:0] p3,
        input logic [FRAC_BITS-1:0] frac);
        longint k0, k1, k2, k3, f, acc;
        k0  = longint'(p0);
        k1  = longint'(p1);
        k2  = longint'(p2);
        k3  = longint'(p3);
        f   = longint'({1'b0, frac});
        acc = 2 * k0 - 5 * k1 + 4 * k2 - k3 + drop_frac((3 * k1 - 3 * k2 + k3 - k0) * f);
        acc = (k2 - k0) + drop_frac(acc * f);
        acc = 2 * k1 + drop_frac(acc * f);
        acc = (acc + 1) >>> 1;
        if (acc > longint'(Q_MAX))
        begin
            acc = longint'(Q_MAX);
        end
        else if (acc < longint'(Q_MIN))
        begin
            acc = longint'(Q_MIN);
        end
        return acc[COORD_W-1:0];
    endfunction

    function automatic int usable_points();
        return (active_count > MAX_POINTS) ? MAX_POINTS : int'(active_count);
    endfunction

    function automatic res_t fixed_result(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic signed [COORD_W-1:0] z,
                                          input logic oor);
        res_t r;
        r.out_x        = x;
        r.out_y        = y;
        r.out_z        = z;
        r.out_of_range = oor;
        return r;
    endfunction

    // Interpolated point for one evaluate item at the current store contents
    function automatic res_t predict_point(input item_t it);
        int                   seg;
        logic [FRAC_BITS-1:0] frac;
        seg  = int'(it.t_position[T_W-1:FRAC_BITS]);
        frac = it.t_position[FRAC_BITS-1:0];
        if (seg + 3 >= usable_points())
        begin
            return fixed_result('0, '0, '0, 1'b1);
        end
        return fixed_result(
            spline_axis(point_store[seg].x, point_store[seg+1].x, point_store[seg+2].x,
                        point_store[seg+3].x, frac),
            spline_axis(point_store[seg].y, point_store[seg+1].y, point_store[seg+2].y,
                        point_store[seg+3].y, frac),
            spline_axis(point_store[seg].z, point_store[seg+1].z, point_store[seg+2].z,
                        point_store[seg+3].z, frac),
            1'b0);
    endfunction

    // Mix of full-range and modest coordinates (about +-16.0)
    function automatic logic signed [COORD_W-1:0] random_coord();
        if ($urandom_range(99) < 40)
        begin
            return $urandom;
        end
        return COORD_W'($urandom_range(2 ** 21)) - COORD_W'(2 ** 20);
    endfunction

    // Random item; evaluations mostly land on usable segments
    function automatic item_t random_item();
        item_t it;
        int    lim;
        int    seg;
        int    pick;
        logic [FRAC_BITS-1:0] frac;
        it.kind        = ($urandom_range(99) < 35) ? KIND_WRITE : KIND_EVAL;
        it.point_index = IDX_W'($urandom);
        it.coord_x     = random_coord();
        it.coord_y     = random_coord();
        it.coord_z     = random_coord();
        lim            = usable_points();
        if (lim >= TAPS && $urandom_range(99) < 80)
        begin
            seg = $urandom_range(lim - TAPS);
        end
        else
        begin
            seg = $urandom_range(MAX_POINTS - 1);
        end
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            frac = '0;
        end
        else if (pick == 1)
        begin
            frac = '1;
        end
        else
        begin
            frac = FRAC_BITS'($urandom);
        end
        it.t_position = {SEG_W'(seg), frac};
        return it;
    endfunction

    // Offer one item, wait for its transfer, then update the predictor
    task automatic send_item(input item_t it, input bit typed, input res_t typed_res);
        res_t want;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_word  <= it;
        item_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        if (it.kind == KIND_WRITE)
        begin
            n_writes++;
            point_store[it.point_index].x = it.coord_x;
            point_store[it.point_index].y = it.coord_y;
            point_store[it.point_index].z = it.coord_z;
        end
        else
        begin
            n_evals++;
            want = typed ? typed_res : predict_point(it);
            if (want.out_of_range)
            begin
                n_misses++;
            end
            expected_results.push_back(want);
        end
    endtask

    // Stop offering and let every pending result and write retire
    task automatic drain_block();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [CNT_W-1:0] value);
        drain_block();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        active_count  = value;
        n_settings++;
    endtask

    // Directed table builders
    function automatic void plan_write(input logic [IDX_W-1:0] idx,
                                       input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic signed [COORD_W-1:0] z);
        plan_row_t r;
        r.kind           = ROW_ITEM;
        r.typed          = 1'b0;
        r.res            = '0;
        r.cfg            = '0;
        r.it.kind        = KIND_WRITE;
        r.it.point_index = idx;
        r.it.coord_x     = x;
        r.it.coord_y     = y;
        r.it.coord_z     = z;
        r.it.t_position  = '1;
        plan.push_back(r);
    endfunction

    function automatic void plan_eval(input logic [T_W-1:0] t, input bit typed,
                                      input res_t res);
        plan_row_t r;
        r.kind           = ROW_ITEM;
        r.typed          = typed;
        r.res            = res;
        r.cfg            = '0;
        r.it.kind        = KIND_EVAL;
        r.it.point_index = '1;
        r.it.coord_x     = 32'hA5A5_5A5A;
        r.it.coord_y     = 32'h5A5A_A5A5;
        r.it.coord_z     = '1;
        r.it.t_position  = t;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(input logic [CNT_W-1:0] value);
        plan_row_t r;
        r.kind  = ROW_CFG;
        r.it    = '0;
        r.typed = 1'b0;
        r.res   = '0;
        r.cfg   = value;
        plan.push_back(r);
    endfunction

    initial
    begin : stimulus
        int               pc_plan [PHASES];
        item_t            it;
        res_t             miss;
        logic [T_W-1:0]   seg1;
        logic [T_W-1:0]   seg2;

        pc_plan = '{64, 5, 127, 4, 100, 37, 64, 0};
        miss    = fixed_result('0, '0, '0, 1'b1);
        seg1    = T_W'(1) << FRAC_BITS;
        seg2    = T_W'(2) << FRAC_BITS;

        // Point count still at its reset value: everything misses
        plan_eval('0, 1'b1, miss);
        plan_eval('1, 1'b1, miss);
        plan_cfg(7'd6);
        // Alternating extremes to drive the cubic into saturation
        plan_write(6'd0, Q_MAX, Q_MIN, '0);
        plan_write(6'd1, Q_MIN, Q_MAX, -32'sd1);
        plan_write(6'd2, Q_MAX, Q_MIN, 32'sh0001_0000);
        plan_write(6'd3, Q_MIN, Q_MAX, Q_MAX);
        plan_write(6'd4, '0, -32'sd1, Q_MIN);
        plan_write(6'd5, 32'sd1, 32'sh1234_5678, 32'shFFFF_8000);
        // Zero fraction lands exactly on the second point of the segment
        plan_eval('0, 1'b1, fixed_result(Q_MIN, Q_MAX, -32'sd1, 1'b0));
        plan_eval(T_W'(16'hFFFF), 1'b0, '0);
        plan_eval(T_W'(16'h8000), 1'b0, '0);
        plan_eval(seg1 | T_W'(1), 1'b0, '0);
        plan_eval(seg2, 1'b1, fixed_result(Q_MIN, Q_MAX, Q_MAX, 1'b0));
        plan_eval(seg2 | T_W'(16'hFFFF), 1'b0, '0);
        // First segment that would need a seventh point
        plan_eval(T_W'(3) << FRAC_BITS, 1'b1, miss);
        plan_write(6'd63, 32'sh0003_8000, -32'sh0002_0000, 32'sh7FFF_0000);
        // Oversized count behaves as a full store
        plan_cfg(7'd127);
        plan_eval((T_W'(60) << FRAC_BITS) | T_W'(16'hFFFF), 1'b0, '0);
        plan_eval(T_W'(61) << FRAC_BITS, 1'b1, miss);
        plan_eval('1, 1'b1, miss);
        // Smallest count with a usable segment
        plan_cfg(7'd4);
        plan_eval('0, 1'b1, fixed_result(Q_MIN, Q_MAX, -32'sd1, 1'b0));
        plan_eval(seg1, 1'b1, miss);

        // Reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole store so no evaluation reads an unwritten point
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            it             = random_item();
            it.kind        = KIND_WRITE;
            it.point_index = IDX_W'(i);
            send_item(it, 1'b0, '0);
        end

        // Directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                write_point_count(plan[i].cfg);
            end
            else
            begin
                send_item(plan[i].it, plan[i].typed, plan[i].res);
            end
        end

        // Random phases: new point count, then an idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            write_point_count(CNT_W'(pc_plan[p]));
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
                1: begin snd_idle_pct = 72; rcv_idle_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_idle_pct = 72; end
                default: begin snd_idle_pct = 27; rcv_idle_pct = 27; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Long output hold while items keep coming: fills the queue
                if (p == 0 && i == 40)
                begin
                    hold_requests++;
                end
                // Sender waits for every result before going on
                if (p == 4 && i == PHASE_ITEMS / 2)
                begin
                    item_valid <= 1'b0;
                    do
                    begin
                        @(posedge clk);
                    end
                    while (expected_results.size() != 0);
                end
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain_block();

        $display("Covered %0d point writes and %0d evaluations (%0d out of range) over %0d",
                 n_writes, n_evals, n_misses, n_settings);
        $display("point count settings and four idling mixes; %0d results checked.", checked);
        if (failures == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d failures", failures);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/crse_pkg.sv
sv/crse_ram.sv
sv/crse_front.sv
sv/crse_fifo.sv
sv/crse_back.sv
sv/catmull_rom_spline_eval_core.sv
tb/catmull_rom_spline_eval_core_test.sv
